@@ hdl/tsh_pkg.sv @@
// shared constants and codes for the thermistor steinhart-hart core
`default_nettype none
package tsh_pkg;

  localparam int ADC_BITS = 10;
  localparam logic [ADC_BITS-1:0] CODE_FS = {ADC_BITS{1'b1}};

  // config register indexes
  localparam logic [1:0] REG_RF     = 2'd0;
  localparam logic [1:0] REG_COEF_A = 2'd1;
  localparam logic [1:0] REG_COEF_B = 2'd2;
  localparam logic [1:0] REG_COEF_C = 2'd3;

  localparam int RF_W   = 22;
  localparam int COEF_W = 40;
  localparam int CFG_W  = 40;

  localparam logic [RF_W-1:0]   RF_RESET     = 22'd10000;
  localparam logic [COEF_W-1:0] COEF_A_RESET = 40'd284078485000;
  localparam logic [COEF_W-1:0] COEF_B_RESET = 40'd66946162000;
  localparam logic [COEF_W-1:0] COEF_C_RESET = 40'd56835503;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // log2 unit: input width, exponent width, fraction bits, latency
  localparam int LOG_IN_W = 22;
  localparam int LOG_E_W  = 5;
  localparam int LOG_FRAC = 32;
  localparam int LOG_W    = LOG_E_W + LOG_FRAC;
  localparam int LOG_LAT  = LOG_FRAC + 1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // divider: quotient bits, numerator and divisor widths
  localparam int DIV_LAT = 17;
  localparam int NUM_W   = 57;
  localparam logic [NUM_W-1:0] NUM_BASE = 57'd100 << 48;

  localparam int D_W = 58;

  localparam logic [DIV_LAT-1:0] T_LIMIT    = 17'd127314;
  localparam logic [17:0]        KELVIN_OFS = 18'd27315;
  localparam logic [17:0]        TEMP_MAX   = 18'd99999;
  localparam logic [17:0]        TEMP_MIN   = 18'h3_954D; // -27315

  // pipeline stage indexes
  localparam int S_A   = LOG_LAT;
  localparam int S_B   = S_A + 1;
  localparam int S_C   = S_A + 2;
  localparam int S_D   = S_A + 3;
  localparam int S_E   = S_A + 4;
  localparam int S_F   = S_A + 5;
  localparam int S_G   = S_A + 6;
  localparam int S_H   = S_A + 7;
  localparam int S_I   = S_A + 8;
  localparam int S_J   = S_A + 9;
  localparam int S_K   = S_A + 10;
  localparam int NSTG  = S_K + DIV_LAT + 2;

endpackage
`default_nettype wire

@@ hdl/tsh_log2.sv @@
// pipelined log2 in q32, one fraction bit per squaring stage
`default_nettype none
module tsh_log2
  import tsh_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [LOG_IN_W-1:0] val_i,
  output logic [LOG_W-1:0]         log_o
);

  logic [30:0]         m_q [LOG_LAT];
  logic [LOG_FRAC-1:0] f_q [LOG_LAT];
  logic [LOG_E_W-1:0]  e_q [LOG_LAT];

  logic [LOG_E_W-1:0] e0;
  logic [30:0]        m0;

  // leading one position
  always_comb begin
    e0 = '0;
    for (int i = 1; i < LOG_IN_W; i++) begin
      if (val_i[i]) e0 = LOG_E_W'(i);
    end
    m0 = 31'(31'(val_i) << (LOG_E_W'(30) - e0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= m0;
      f_q[0] <= '0;
      e_q[0] <= e0;
    end
  end

  for (genvar g = 1; g < LOG_LAT; g++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] top;
    assign sq  = m_q[g-1] * m_q[g-1];
    assign top = sq[61:30];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[g] <= top[31] ? top[31:1] : top[30:0];
        f_q[g] <= {f_q[g-1][LOG_FRAC-2:0], top[31]};
        e_q[g] <= e_q[g-1];
      end
    end
  end

  assign log_o = {e_q[LOG_LAT-1], f_q[LOG_LAT-1]};

endmodule
`default_nettype wire

@@ hdl/tsh_div.sv @@
// restoring divider, one quotient bit per stage
`default_nettype none
module tsh_div
  import tsh_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [NUM_W-1:0]   den_i,
  output logic [DIV_LAT-1:0]      quo_o
);

  localparam int CW = NUM_W + DIV_LAT;

  logic [NUM_W-1:0]   rem_q [DIV_LAT];
  logic [NUM_W-1:0]   den_q [DIV_LAT];
  logic [DIV_LAT-1:0] quo_q [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_bit
    localparam int B = DIV_LAT - 1 - j;
    logic [NUM_W-1:0]   rem_in;
    logic [NUM_W-1:0]   den_in;
    logic [DIV_LAT-1:0] quo_in;
    logic [CW-1:0]      dsh;
    logic               ge;
    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end
    assign dsh = CW'(den_in) << B;
    assign ge  = CW'(rem_in) >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? NUM_W'(CW'(rem_in) - dsh) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= {quo_in[DIV_LAT-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule
`default_nettype wire

@@ hdl/thermistor_steinhart_hart_core.sv @@
// thermistor steinhart-hart linearization core, top level
//
// input channel: adc_code_i with in_valid_i / in_ready_o, one sample per item.
// output channel: temp_centi_o (signed 0.01 degC) and status_o with
// out_valid_o / out_ready_i, exactly one result per sample, in order.
// config: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 fixed resistance, 1..3 coefficients a, b, c); write only while idle.
// the pipeline has 62 register stages: 33 for the log2 squaring stages,
// 10 for the ln scale, powers, coefficient terms, sum and rounding, 1 for
// the divider operands, 17 for the restoring divider (one quotient bit each)
// and 1 for limits. throughput is one item per cycle unless the receiver stalls.
// when the receiver stalls, the whole pipeline holds; an empty last stage
// lets it advance, so bubbles drain and input is still taken.
// reset clears all valid bits and loads the default resistor and
// coefficients.
`default_nettype none
module thermistor_steinhart_hart_core
  import tsh_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [ADC_BITS-1:0] adc_code_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [17:0]              temp_centi_o,
  output logic [1:0]               status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CFG_W-1:0]    cfg_data_i
);

  logic [RF_W-1:0]   rf_q;
  logic [COEF_W-1:0] ca_q, cb_q, cc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= RF_RESET;
      ca_q <= COEF_A_RESET;
      cb_q <= COEF_B_RESET;
      cc_q <= COEF_C_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RF:     rf_q <= cfg_data_i[RF_W-1:0];
        REG_COEF_A: ca_q <= cfg_data_i;
        REG_COEF_B: cb_q <= cfg_data_i;
        REG_COEF_C: cc_q <= cfg_data_i;
        default:    rf_q <= rf_q;
      endcase
    end
  end

  logic en;
  logic [NSTG-1:0] v_q;

  assign en          = ~v_q[NSTG-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // log2 lanes
  logic [LOG_IN_W-1:0] rf_eff, fsc_in, code_in;
  logic [LOG_W-1:0]    lg_r, lg_f, lg_c;

  assign rf_eff  = (rf_q == '0) ? LOG_IN_W'(1) : rf_q;
  assign fsc_in  = LOG_IN_W'(CODE_FS - adc_code_i);
  assign code_in = LOG_IN_W'(adc_code_i);

  tsh_log2 u_log_r (.clk_i, .en_i(en), .val_i(rf_eff),  .log_o(lg_r));
  tsh_log2 u_log_f (.clk_i, .en_i(en), .val_i(fsc_in),  .log_o(lg_f));
  tsh_log2 u_log_c (.clk_i, .en_i(en), .val_i(code_in), .log_o(lg_c));

  // side info traveling with each item
  logic [1:0] st_q [NSTG-1];
  logic       ng_q [NSTG-1];
  logic [1:0] st_in, st_k;
  logic       neg_a;

  logic [NUM_W-1:0] num_j, den_j;
  logic             bad_j, ovf;

  assign st_in = (adc_code_i == '0)     ? ST_ZERO :
                 (adc_code_i == CODE_FS) ? ST_FULL : ST_OK;
  assign ovf   = (DIV_LAT+NUM_W)'(num_j) >= {den_j, {DIV_LAT{1'b0}}};
  assign st_k  = (st_q[S_K-1] != ST_OK) ? st_q[S_K-1] :
                 (bad_j || ovf)          ? ST_SAT : ST_OK;

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st_in;
      ng_q[0] <= 1'b0;
      for (int k = 1; k < NSTG-1; k++) begin
        if (k == S_K) begin
          st_q[k] <= st_k;
        end else begin
          st_q[k] <= st_q[k-1];
        end
        if (k == S_A) begin
          ng_q[k] <= neg_a;
        end else begin
          ng_q[k] <= ng_q[k-1];
        end
      end
    end
  end

  // stage a: log2 of resistance, sign and magnitude
  logic signed [LOG_W:0] l2;
  logic [LOG_W-1:0]      mag_a;

  assign l2    = $signed({1'b0, lg_r}) + $signed({1'b0, lg_f}) - $signed({1'b0, lg_c});
  assign neg_a = l2[LOG_W];

  always_ff @(posedge clk_i) begin
    if (en) mag_a <= neg_a ? LOG_W'(-l2) : LOG_W'(l2);
  end

  // stage b/c: scale by ln 2 into q24
  logic [63:0] pl_b;
  logic [36:0] ph_b;
  logic [68:0] lnf;
  logic [28:0] lm_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_b <= mag_a[31:0] * LN2_Q32;
      ph_b <= mag_a[LOG_W-1:32] * LN2_Q32;
    end
  end

  assign lnf = {ph_b, 32'b0} + 69'(pl_b);

  always_ff @(posedge clk_i) begin
    if (en) lm_c <= lnf[68:40];
  end

  // stage d: square
  logic [57:0] sq_d;
  logic [33:0] l2_d;
  logic [28:0] lm_d;

  assign sq_d = lm_c * lm_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      l2_d <= sq_d[57:24];
      lm_d <= lm_c;
    end
  end

  // stage e/f: cube and linear term
  logic [COEF_W-1:0] cbm, ccm;
  logic [45:0]       ql_e, qh_e;
  logic [48:0]       bl_e, bh_e;
  logic [62:0]       l3f;
  logic [68:0]       pbf;
  logic [38:0]       l3_f;
  logic [44:0]       pb_f, pb_g, pb_h;

  assign cbm = cb_q[COEF_W-1] ? COEF_W'(-cb_q) : cb_q;
  assign ccm = cc_q[COEF_W-1] ? COEF_W'(-cc_q) : cc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ql_e <= l2_d[16:0] * lm_d;
      qh_e <= l2_d[33:17] * lm_d;
      bl_e <= cbm[19:0] * lm_d;
      bh_e <= cbm[39:20] * lm_d;
    end
  end

  assign l3f = {qh_e, 17'b0} + 63'(ql_e);
  assign pbf = {bh_e, 20'b0} + 69'(bl_e);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l3_f <= l3f[62:24];
      pb_f <= pbf[68:24];
    end
  end

  // stage g/h: cubic term
  logic [39:0] p00_g, p10_g;
  logic [38:0] p01_g, p11_g;
  logic [78:0] pcf;
  logic [54:0] pc_h;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p00_g <= ccm[19:0] * l3_f[19:0];
      p01_g <= ccm[19:0] * l3_f[38:20];
      p10_g <= ccm[39:20] * l3_f[19:0];
      p11_g <= ccm[39:20] * l3_f[38:20];
      pb_g  <= pb_f;
    end
  end

  assign pcf = {p11_g, 40'b0} + {18'b0, (41'(p01_g) + 41'(p10_g)), 20'b0} + 79'(p00_g);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_h <= pcf[78:24];
      pb_h <= pb_g;
    end
  end

  // stage i: denominator
  logic              bn, cn;
  logic signed [D_W-1:0] tb, tc, ta, d_i;

  assign bn = cb_q[COEF_W-1] ^ ng_q[S_H];
  assign cn = cc_q[COEF_W-1] ^ ng_q[S_H];
  assign ta = D_W'($signed(ca_q));
  assign tb = bn ? -$signed(D_W'(pb_h)) : $signed(D_W'(pb_h));
  assign tc = cn ? -$signed(D_W'(pc_h)) : $signed(D_W'(pc_h));

  always_ff @(posedge clk_i) begin
    if (en) d_i <= ta + tb + tc;
  end

  // stage j: rounding numerator
  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_j <= d_i[D_W-1] || (d_i == '0);
      num_j <= NUM_BASE + NUM_W'(d_i[D_W-2:1]);
      den_j <= d_i[NUM_W-1:0];
    end
  end

  // stage k: operands into divider
  logic [NUM_W-1:0]   num_k, den_k;
  logic [DIV_LAT-1:0] quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_k <= num_j;
      den_k <= den_j;
    end
  end

  tsh_div u_div (.clk_i, .en_i(en), .num_i(num_k), .den_i(den_k), .quo_o(quo));

  // output stage: limits and offset
  logic [17:0] temp_q;
  logic [1:0]  sta_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (st_q[NSTG-2])
        ST_ZERO: begin
          temp_q <= TEMP_MIN;
          sta_q  <= ST_ZERO;
        end
        ST_FULL: begin
          temp_q <= TEMP_MAX;
          sta_q  <= ST_FULL;
        end
        ST_OK: begin
          if (quo > T_LIMIT) begin
            temp_q <= TEMP_MAX;
            sta_q  <= ST_SAT;
          end else begin
            temp_q <= 18'(quo) - KELVIN_OFS;
            sta_q  <= ST_OK;
          end
        end
        default: begin
          temp_q <= TEMP_MAX;
          sta_q  <= ST_SAT;
        end
      endcase
    end
  end

  assign temp_centi_o = temp_q;
  assign status_o     = sta_q;

endmodule
`default_nettype wire
